>>> design/arw_pkg.sv
`default_nettype none

package arw_pkg;

    // Default sizes
    localparam int NUM_CHANNELS_DEF = 64;
    localparam int WINDOW_BITS_DEF  = 64;

    // Fixed field widths
    localparam int CHANNEL_ID_W  = 6;
    localparam int SEQ_NUM_W     = 64;
    localparam int WINDOW_SIZE_W = 8;
    localparam int CFG_INDEX_W   = 8;
    localparam int CFG_DATA_W    = 8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CHECK_ENABLE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE  = 8'd1;

    // Reset value of the window register
    localparam logic [WINDOW_SIZE_W-1:0] WINDOW_SIZE_RST = 8'd64;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT    = 2'd0,
        VERDICT_TOO_OLD   = 2'd1,
        VERDICT_DUPLICATE = 2'd2
    } verdict_t;

    typedef enum logic {
        ST_IDLE,
        ST_CHECK
    } state_t;

    // Per-beat control into the check logic
    typedef struct packed {
        logic check_enable;
        logic chan_ok;
        logic chan_init;
    } check_ctrl_t;

    // Decision out of the check logic
    typedef struct packed {
        verdict_t verdict;
        logic     wr_en;
    } check_res_t;

endpackage

`default_nettype wire

>>> design/arw_if.sv
`default_nettype none

// Input item channel
interface arw_req_if;
    logic                              valid;
    logic                              ready;
    logic [arw_pkg::CHANNEL_ID_W-1:0]  channel_id;
    logic [arw_pkg::SEQ_NUM_W-1:0]     seq_num;

    modport source (output valid, output channel_id, output seq_num, input ready);
    modport sink   (input valid, input channel_id, input seq_num, output ready);
endinterface

// Result channel
interface arw_rsp_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic [1:0] verdict;

    modport source (output valid, output accepted, output verdict, input ready);
    modport sink   (input valid, input accepted, input verdict, output ready);
endinterface

// Register write channel
interface arw_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [arw_pkg::CFG_INDEX_W-1:0]  index;
    logic [arw_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/arw_state_mem.sv
`default_nettype none

// Single-port-write, registered-read channel state RAM
module arw_state_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 128,
    parameter int AW    = 6
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> design/arw_check.sv
`default_nettype none

// Window decision and state update for one beat
module arw_check #(
    parameter int WINDOW_BITS = 64
) (
    input  wire arw_pkg::check_ctrl_t                  ctrl,
    input  wire logic [arw_pkg::WINDOW_SIZE_W-1:0]     eff_window,
    input  wire logic [arw_pkg::SEQ_NUM_W-1:0]         seq_num,
    input  wire logic [arw_pkg::SEQ_NUM_W-1:0]         highest,
    input  wire logic [WINDOW_BITS-1:0]                bitmap,
    output arw_pkg::check_res_t                        res,
    output logic      [arw_pkg::SEQ_NUM_W-1:0]         new_highest,
    output logic      [WINDOW_BITS-1:0]                new_bitmap
);

    localparam int IDX_W = $clog2(WINDOW_BITS);
    localparam logic [WINDOW_BITS-1:0]        BM_ONE  = WINDOW_BITS'(1);
    localparam logic [arw_pkg::SEQ_NUM_W-1:0] WIN_MAX = arw_pkg::SEQ_NUM_W'(WINDOW_BITS);

    logic [arw_pkg::SEQ_NUM_W-1:0] diff_up;
    logic [arw_pkg::SEQ_NUM_W-1:0] diff_dn;
    logic                          is_newer;
    logic [IDX_W-1:0]              bit_idx;

    assign is_newer = seq_num > highest;
    assign diff_up  = seq_num - highest;
    assign diff_dn  = highest - seq_num;
    assign bit_idx  = diff_dn[IDX_W-1:0];

    always_comb
    begin
        res.verdict = arw_pkg::VERDICT_ACCEPT;
        res.wr_en   = 1'b0;
        new_highest = highest;
        new_bitmap  = bitmap;
        if (ctrl.check_enable)
        begin
            if (!ctrl.chan_ok)
            begin
                res.verdict = arw_pkg::VERDICT_TOO_OLD;
            end
            else if (!ctrl.chan_init)
            begin
                // first number on the channel opens the window
                res.wr_en   = 1'b1;
                new_highest = seq_num;
                new_bitmap  = BM_ONE;
            end
            else if (is_newer)
            begin
                // slide window up to the new highest
                res.wr_en   = 1'b1;
                new_highest = seq_num;
                if (diff_up >= WIN_MAX)
                begin
                    new_bitmap = BM_ONE;
                end
                else
                begin
                    new_bitmap = (bitmap << diff_up[IDX_W-1:0]) | BM_ONE;
                end
            end
            else if (diff_dn >= arw_pkg::SEQ_NUM_W'(eff_window))
            begin
                res.verdict = arw_pkg::VERDICT_TOO_OLD;
            end
            else if (bitmap[bit_idx])
            begin
                res.verdict = arw_pkg::VERDICT_DUPLICATE;
            end
            else
            begin
                res.wr_en  = 1'b1;
                new_bitmap = bitmap | (BM_ONE << bit_idx);
            end
        end
    end

endmodule

`default_nettype wire

>>> design/anti_replay_window_check.sv
// Per-channel anti-replay check with a sliding window of sequence numbers.
//
// Channels:
//   req - input beat: channel_id and 64-bit seq_num, taken on valid && ready.
//   rsp - result beat: accepted and verdict (0 accept, 1 too old, 2 duplicate).
//   cfg - register write: index 0 check_enable, index 1 window_size; other
//         indexes are ignored. Always ready. Write only while idle.
// Timing:
//   A beat accepted at a clock edge reads its channel entry from the state RAM
//   at that edge; the decision and write-back happen in the check state, where
//   the result is loaded into the output register. A new beat is taken only
//   once the previous one has been decided and written back to the state RAM.
// Stall:
//   The output register lets the next beat be taken while a result waits.
//   If the previous result is still not taken when a decision is ready, the
//   check stage holds (no write-back) until rsp.ready.
// Reset:
//   All channels become uninitialized at once (flags in flops, no sweep);
//   checking is disabled and the window is 64.
`default_nettype none

module anti_replay_window_check #(
    parameter int NUM_CHANNELS = arw_pkg::NUM_CHANNELS_DEF,
    parameter int WINDOW_BITS  = arw_pkg::WINDOW_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    arw_req_if.sink    req,
    arw_rsp_if.source  rsp,
    arw_cfg_if.sink    cfg
);

    localparam int AW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int ENTRY_W = arw_pkg::SEQ_NUM_W + WINDOW_BITS;
    localparam int CH_CMP_W = arw_pkg::CHANNEL_ID_W + 1;

    // Configuration registers
    logic                              check_enable_reg;
    logic [arw_pkg::WINDOW_SIZE_W-1:0] window_size_reg;
    logic [arw_pkg::WINDOW_SIZE_W-1:0] eff_window;

    // Control and held beat
    arw_pkg::state_t                   state_reg, state_next;
    logic [arw_pkg::CHANNEL_ID_W-1:0]  channel_id_reg;
    logic [arw_pkg::SEQ_NUM_W-1:0]     seq_num_reg;
    logic [NUM_CHANNELS-1:0]           chan_init_reg;

    // Output register
    logic                              rsp_valid_reg, rsp_valid_next;
    arw_pkg::verdict_t                 verdict_reg;

    logic                              req_fire;
    logic                              commit;
    logic [AW-1:0]                     ch_addr;
    logic                              chan_ok;
    logic [ENTRY_W-1:0]                rd_entry;
    logic [ENTRY_W-1:0]                wr_entry;
    arw_pkg::check_ctrl_t              ctrl;
    arw_pkg::check_res_t               res;
    logic [arw_pkg::SEQ_NUM_W-1:0]     new_highest;
    logic [WINDOW_BITS-1:0]            new_bitmap;
    logic                              mem_we;

    assign req_fire = req.valid && req.ready;
    assign ch_addr  = channel_id_reg[AW-1:0];
    assign chan_ok  = CH_CMP_W'(channel_id_reg) < CH_CMP_W'(NUM_CHANNELS);

    // Register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_enable_reg <= 1'b0;
            window_size_reg  <= arw_pkg::WINDOW_SIZE_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == arw_pkg::REG_CHECK_ENABLE)
            begin
                check_enable_reg <= cfg.data[0];
            end
            else if (cfg.index == arw_pkg::REG_WINDOW_SIZE)
            begin
                window_size_reg <= cfg.data;
            end
        end
    end

    // Zero or oversize window means the full bitmap
    assign eff_window = (window_size_reg == '0 ||
                         window_size_reg > arw_pkg::WINDOW_SIZE_W'(WINDOW_BITS))
                        ? arw_pkg::WINDOW_SIZE_W'(WINDOW_BITS) : window_size_reg;

    // Channel state RAM: {highest, bitmap}
    arw_state_mem #(
        .DEPTH (NUM_CHANNELS),
        .WIDTH (ENTRY_W),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (ch_addr),
        .wr_data (wr_entry),
        .rd_en   (req_fire),
        .rd_addr (req.channel_id[AW-1:0]),
        .rd_data (rd_entry)
    );

    // Decision logic
    assign ctrl.check_enable = check_enable_reg;
    assign ctrl.chan_ok      = chan_ok;
    assign ctrl.chan_init    = chan_ok && chan_init_reg[ch_addr];

    arw_check #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_check (
        .ctrl        (ctrl),
        .eff_window  (eff_window),
        .seq_num     (seq_num_reg),
        .highest     (rd_entry[ENTRY_W-1:WINDOW_BITS]),
        .bitmap      (rd_entry[WINDOW_BITS-1:0]),
        .res         (res),
        .new_highest (new_highest),
        .new_bitmap  (new_bitmap)
    );

    assign wr_entry = {new_highest, new_bitmap};
    assign mem_we   = commit && res.wr_en;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        commit         = 1'b0;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        case (state_reg)
            arw_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = arw_pkg::ST_CHECK;
                end
            end
            arw_pkg::ST_CHECK:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    commit         = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = arw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = arw_pkg::ST_IDLE;
            end
        endcase
    end

    assign req.ready = (state_reg == arw_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= arw_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
            chan_init_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (mem_we)
            begin
                chan_init_reg[ch_addr] <= 1'b1;
            end
        end
    end

    // Held beat and result payload
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            channel_id_reg <= req.channel_id;
            seq_num_reg    <= req.seq_num;
        end
        if (commit)
        begin
            verdict_reg <= res.verdict;
        end
    end

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.verdict  = verdict_reg;
    assign rsp.accepted = (verdict_reg == arw_pkg::VERDICT_ACCEPT);

    // Checks
    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> state_reg == arw_pkg::ST_CHECK)
        else $error("accepted beat did not enter check stage");

    a_write_only_in_check: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == arw_pkg::ST_CHECK && check_enable_reg && chan_ok)
        else $error("state write outside an enabled check");

    a_no_write_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        commit && !check_enable_reg |-> !mem_we && res.verdict == arw_pkg::VERDICT_ACCEPT)
        else $error("disabled checking changed state or rejected");

    a_init_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> chan_init_reg[$past(ch_addr)])
        else $error("channel not marked initialized after write-back");

    a_no_overwrite_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> !rsp_valid_reg || rsp.ready)
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import arw_pkg::*;

    // Cycles after the last result before a register write or the end
    localparam int DRAIN_CYCLES = 4;
    // Long receiver hold-off used to back the block up
    localparam int HOLD_CYCLES  = 400;
    // Watchdog: cycles with no beat on any channel
    localparam int QUIET_LIMIT  = 5000;
    localparam int PHASE_BEATS  = 150;
    localparam int NUM_PHASES   = 6;
    localparam int NUM_DIR_ROWS = 31;

    // Index that maps to no register; writes to it must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 8'd7;

    localparam logic [SEQ_NUM_W-1:0] SEQ_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic {
        ROW_BEAT,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t                  kind;
        logic [CHANNEL_ID_W-1:0]    ch;
        logic [SEQ_NUM_W-1:0]       sn;
        bit                         typed;
        verdict_t                   want;
        logic [CFG_INDEX_W-1:0]     idx;
        logic [CFG_DATA_W-1:0]      val;
    } dir_row_t;

    logic clk;
    logic rst_n;

    arw_req_if req_bus ();
    arw_rsp_if rsp_bus ();
    arw_cfg_if cfg_bus ();

    anti_replay_window_check i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    // Shadow replay state and registers
    bit                      chan_live [NUM_CHANNELS_DEF];
    logic [SEQ_NUM_W-1:0]    seq_top   [NUM_CHANNELS_DEF];
    logic [63:0]             seen_map  [NUM_CHANNELS_DEF];
    logic                    chk_en;
    logic [WINDOW_SIZE_W-1:0] win_reg;

    verdict_t pending_verdicts [$];

    int beats_sent;
    int results_checked;
    int n_errors;
    int verdict_hits [3];
    int quiet_cycles;

    // Receiver controls, set by the stimulus process
    int rsp_stall_pct;
    int hold_requests;

    dir_row_t dir_rows [NUM_DIR_ROWS];

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Width of the replay window currently in force
    function automatic int live_window();
        if (win_reg == '0 || win_reg > WINDOW_SIZE_W'(WINDOW_BITS_DEF))
            return WINDOW_BITS_DEF;
        return int'(win_reg);
    endfunction

    // Verdict for one sequence number; updates the shadow state
    function automatic verdict_t predict_verdict(input logic [CHANNEL_ID_W-1:0] ch,
                                                 input logic [SEQ_NUM_W-1:0] sn);
        logic [SEQ_NUM_W-1:0] gap;
        verdict_t             v;
        v = VERDICT_ACCEPT;
        if (chk_en)
        begin
            if (!chan_live[ch])
            begin
                chan_live[ch] = 1'b1;
                seq_top[ch]   = sn;
                seen_map[ch]  = 64'd1;
            end
            else if (sn > seq_top[ch])
            begin
                gap = sn - seq_top[ch];
                if (gap >= SEQ_NUM_W'(WINDOW_BITS_DEF))
                    seen_map[ch] = 64'd1;
                else
                    seen_map[ch] = (seen_map[ch] << gap) | 64'd1;
                seq_top[ch] = sn;
            end
            else
            begin
                gap = seq_top[ch] - sn;
                if (gap >= SEQ_NUM_W'(live_window()))
                    v = VERDICT_TOO_OLD;
                else if (seen_map[ch][gap[5:0]])
                    v = VERDICT_DUPLICATE;
                else
                    seen_map[ch][gap[5:0]] = 1'b1;
            end
        end
        return v;
    endfunction

    // Random beat: mostly in-order traffic around the channel's top number
    task automatic pick_item(output logic [CHANNEL_ID_W-1:0] ch,
                             output logic [SEQ_NUM_W-1:0] sn);
        int                   r;
        logic [SEQ_NUM_W-1:0] top;
        r = $urandom_range(99);
        if (r < 10)
        begin
            // noise
            ch = CHANNEL_ID_W'($urandom);
            sn = {$urandom, $urandom};
        end
        else
        begin
            ch  = CHANNEL_ID_W'((r < 20) ? $urandom_range(63) : $urandom_range(7));
            top = seq_top[ch];
            r   = $urandom_range(99);
            if (!chan_live[ch])
                sn = (r < 50) ? {$urandom, $urandom} : SEQ_NUM_W'($urandom_range(1000));
            else if (r < 40)
                sn = top + SEQ_NUM_W'($urandom_range(4, 1));
            else if (r < 50)
                sn = top + SEQ_NUM_W'($urandom_range(130, 5));
            else if (r < 55)
                sn = top;
            else if (r < 58)
                sn = top + {$urandom, $urandom};
            else
                sn = top - SEQ_NUM_W'($urandom_range(live_window() + 1, 0));
        end
    endtask

    // Offer one beat and wait for it to be taken
    task automatic send_beat(input logic [CHANNEL_ID_W-1:0] ch,
                             input logic [SEQ_NUM_W-1:0] sn,
                             input bit typed, input verdict_t want);
        verdict_t v;
        req_bus.valid      <= 1'b1;
        req_bus.channel_id <= ch;
        req_bus.seq_num    <= sn;
        do @(posedge clk); while (!(req_bus.valid && req_bus.ready));
        v = predict_verdict(ch, sn);
        pending_verdicts.push_back(typed ? want : v);
        beats_sent++;
    endtask

    // Let the block drain, then write one register
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        req_bus.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
        cfg_bus.valid <= 1'b0;
        if (idx == REG_CHECK_ENABLE)
            chk_en = val[0];
        else if (idx == REG_WINDOW_SIZE)
            win_reg = val;
    endtask

    // Result side: random stalls plus an occasional long hold-off
    initial
    begin : rsp_side
        int hold_left;
        int served;
        hold_left     = 0;
        served        = 0;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (served != hold_requests)
            begin
                served        = hold_requests;
                hold_left     = HOLD_CYCLES;
                rsp_bus.ready <= 1'b0;
            end
            else
                rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // Result check and watchdog
    always @(posedge clk)
    begin : rsp_check
        verdict_t exp_v;
        if (rst_n)
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (rsp_bus.verdict < 2'd3)
                    verdict_hits[rsp_bus.verdict]++;
                if (pending_verdicts.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: accepted=%0b verdict=%0d",
                             $time, rsp_bus.accepted, rsp_bus.verdict);
                    n_errors++;
                end
                else
                begin
                    exp_v = pending_verdicts.pop_front();
                    results_checked++;
                    if (rsp_bus.accepted !== (exp_v == VERDICT_ACCEPT))
                    begin
                        $display("%0t: accepted mismatch: expected %0b, actual %0b",
                                 $time, exp_v == VERDICT_ACCEPT, rsp_bus.accepted);
                        n_errors++;
                    end
                    if (rsp_bus.verdict !== exp_v)
                    begin
                        $display("%0t: verdict mismatch: expected %0d (%s), actual %0d",
                                 $time, exp_v, exp_v.name(), rsp_bus.verdict);
                        n_errors++;
                    end
                end
            end

            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                         $time, QUIET_LIMIT, pending_verdicts.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin : stim
        logic [CHANNEL_ID_W-1:0] ch;
        logic [SEQ_NUM_W-1:0]    sn;
        int                      send_idle;
        logic                    ph_en;
        logic [CFG_DATA_W-1:0]   ph_win;

        rst_n              = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.channel_id = '0;
        req_bus.seq_num    = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = '0;
        cfg_bus.data       = '0;
        rsp_stall_pct      = 0;
        hold_requests      = 0;
        beats_sent         = 0;
        results_checked    = 0;
        n_errors           = 0;
        quiet_cycles       = 0;
        verdict_hits       = '{0, 0, 0};
        chk_en             = 1'b0;
        win_reg            = WINDOW_SIZE_RST;
        for (int c = 0; c < NUM_CHANNELS_DEF; c++)
        begin
            chan_live[c] = 1'b0;
            seq_top[c]   = '0;
            seen_map[c]  = '0;
        end

        // Directed cases; rows with typed set carry an obvious verdict
        dir_rows = '{
            // checking off after reset: everything passes, no state kept
            '{ROW_BEAT, 6'd0,  64'd0,     1'b1, VERDICT_ACCEPT,    8'd0, 8'd0},
            '{ROW_BEAT, 6'd63, SEQ_MAX,   1'b1, VERDICT_ACCEPT,    8'd0, 8'd0},
            '{ROW_BEAT, 6'd5,  64'd5,     1'b1, VERDICT_ACCEPT,    8'd0, 8'd0},
            '{ROW_CFG,  6'd0,  64'd0,     1'b0, VERDICT_ACCEPT,    REG_CHECK_ENABLE, 8'd1},
            '{ROW_CFG,  6'd0,  64'd0,     1'b0, VERDICT_ACCEPT,    REG_SPARE, 8'd0},
            // first number, equal to top, window edge, duplicate, shifts
            '{ROW_BEAT, 6'd0,  64'd100,   1'b1, VERDICT_ACCEPT,    8'd0, 8'd0},
            '{ROW_BEAT, 6'd0,  64'd100,   1'b1, VERDICT_DUPLICATE, 8'd0, 8'd0},
            '{ROW_BEAT, 6'd0,  64'd36,    1'b1, VERDICT_TOO_OLD,   8'd0, 8'd0},
            '{ROW_BEAT, 6'd0,  64'd37,    1'b0, VERDICT_ACCEPT,    8'd0, 8'd0},
            '{ROW_BEAT, 6'd0,  64'd37,    1'b1, VERDICT_DUPLICATE, 8'd0, 8'd0},
            '{ROW_BEAT, 6'd0,  64'd101,   1'b0, VERDICT_ACCEPT,    8'd0, 8'd0},
            '{ROW_BEAT, 6'd0,  64'd165,   1'b0, VERDICT_ACCEPT,    8'd0, 8'd0},
            '{ROW_BEAT, 6'd0,  64'd102,   1'b0, VERDICT_ACCEPT,    8'd0, 8'd0},
            // extremes of the number space, no wrap
            '{ROW_BEAT, 6'd63, SEQ_MAX,   1'b1, VERDICT_ACCEPT,    8'd0, 8'd0},
            '{ROW_BEAT, 6'd63, 64'd0,     1'b1, VERDICT_TOO_OLD,   8'd0, 8'd0},
            '{ROW_BEAT, 6'd63, SEQ_MAX-1, 1'b0, VERDICT_ACCEPT,    8'd0, 8'd0},
            '{ROW_BEAT, 6'd1,  64'd0,     1'b1, VERDICT_ACCEPT,    8'd0, 8'd0},
            '{ROW_BEAT, 6'd1,  SEQ_MAX,   1'b0, VERDICT_ACCEPT,    8'd0, 8'd0},
            '{ROW_BEAT, 6'd1,  64'd0,     1'b1, VERDICT_TOO_OLD,   8'd0, 8'd0},
            // window 0 reads as full width
            '{ROW_CFG,  6'd0,  64'd0,     1'b0, VERDICT_ACCEPT,    REG_WINDOW_SIZE, 8'd0},
            '{ROW_BEAT, 6'd0,  64'd102,   1'b0, VERDICT_ACCEPT,    8'd0, 8'd0},
            '{ROW_CFG,  6'd0,  64'd0,     1'b0, VERDICT_ACCEPT,    REG_WINDOW_SIZE, 8'd8},
            '{ROW_BEAT, 6'd0,  64'd157,   1'b1, VERDICT_TOO_OLD,   8'd0, 8'd0},
            '{ROW_BEAT, 6'd0,  64'd158,   1'b0, VERDICT_ACCEPT,    8'd0, 8'd0},
            // oversized window clamps to full width
            '{ROW_CFG,  6'd0,  64'd0,     1'b0, VERDICT_ACCEPT,    REG_WINDOW_SIZE, 8'd255},
            '{ROW_BEAT, 6'd0,  64'd101,   1'b1, VERDICT_TOO_OLD,   8'd0, 8'd0},
            '{ROW_BEAT, 6'd0,  64'd103,   1'b0, VERDICT_ACCEPT,    8'd0, 8'd0},
            '{ROW_CFG,  6'd0,  64'd0,     1'b0, VERDICT_ACCEPT,    REG_WINDOW_SIZE, 8'd1},
            '{ROW_BEAT, 6'd2,  64'd10,    1'b1, VERDICT_ACCEPT,    8'd0, 8'd0},
            '{ROW_BEAT, 6'd2,  64'd9,     1'b1, VERDICT_TOO_OLD,   8'd0, 8'd0},
            '{ROW_BEAT, 6'd2,  64'd10,    1'b1, VERDICT_DUPLICATE, 8'd0, 8'd0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIR_ROWS; i++)
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            else
                send_beat(dir_rows[i].ch, dir_rows[i].sn, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random phases: register setting, idle pattern and receiver stall rate per phase
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            ph_en     = 1'b1;
            send_idle = 0;
            case (ph)
                0: ph_win = 8'd64;
                1:
                begin
                    ph_win    = CFG_DATA_W'($urandom_range(63, 1));
                    send_idle = 80;
                end
                2: ph_win = 8'd0;
                3:
                begin
                    ph_win    = 8'd200;
                    send_idle = 12;
                end
                4:
                begin
                    ph_win = 8'd16;
                    ph_en  = 1'b0;
                end
                default: ph_win = CFG_DATA_W'($urandom_range(255));
            endcase
            write_reg(REG_CHECK_ENABLE, {7'd0, ph_en});
            write_reg(REG_WINDOW_SIZE, ph_win);
            case (ph)
                2: rsp_stall_pct = 80;
                3: rsp_stall_pct = 12;
                default: rsp_stall_pct = 0;
            endcase
            // last phase: receiver backs off for a long stretch
            if (ph == NUM_PHASES - 1)
                hold_requests++;

            repeat (PHASE_BEATS)
            begin
                while ($urandom_range(99) < send_idle)
                begin
                    req_bus.valid <= 1'b0;
                    @(posedge clk);
                end
                pick_item(ch, sn);
                send_beat(ch, sn, 1'b0, VERDICT_ACCEPT);
            end
        end

        // Drain
        req_bus.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d beats in a directed pass and %0d random phases; checked %0d results.",
                 beats_sent, NUM_PHASES, results_checked);
        $display("Verdicts seen: %0d accept, %0d too old, %0d duplicate; %0d mismatches.",
                 verdict_hits[0], verdict_hits[1], verdict_hits[2], n_errors);
        if (n_errors == 0 && pending_verdicts.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
